>>> hdl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> hdl/x10ce_pkg.sv
`timescale 1ns / 1ps
package x10ce_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTRW  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNTW  = $clog2(QDEPTH + 1);

    localparam int FRAME_MAX = 8;
    localparam int IDXW      = $clog2(FRAME_MAX);

    localparam logic [1:0] OP_PL_ADDR = 2'd0;
    localparam logic [1:0] OP_PL_FUNC = 2'd1;
    localparam logic [1:0] OP_RF_STD  = 2'd2;
    localparam logic [1:0] OP_RF_SEC  = 2'd3;

    localparam logic [7:0] FN_ON      = 8'd2;
    localparam logic [7:0] FN_OFF     = 8'd3;
    localparam logic [7:0] FN_DIM     = 8'd4;
    localparam logic [7:0] FN_BRIGHT  = 8'd5;
    localparam logic [7:0] FN_EXT_DIM = 8'd16;

    localparam logic [7:0] HDR_PL_ADDR  = 8'h04;
    localparam logic [7:0] HDR_PL_FUNC  = 8'h06;
    localparam logic [7:0] HDR_PL_EXT   = 8'h07;
    localparam logic [7:0] EXT_CMD      = 8'h02;
    localparam logic [7:0] EXT_TRAILER  = 8'h31;
    localparam logic [7:0] SYNC_BYTE    = 8'hEB;
    localparam logic [7:0] RF_HDR_STD   = 8'h20;
    localparam logic [7:0] RF_HDR_LONG  = 8'h29;
    localparam logic [7:0] RF_FN_DIM    = 8'h98;
    localparam logic [7:0] RF_FN_BRIGHT = 8'h88;
    localparam logic [7:0] ADDR_CHECK   = 8'h0F;

    typedef struct packed {
        logic [FRAME_MAX-1:0][7:0] bytes;
        logic [IDXW-1:0]           first_idx;
        logic [IDXW-1:0]           last_idx;
        logic                      error;
    } frame_desc_t;

    function automatic logic [3:0] pl_code(input logic [3:0] v);
        logic [3:0] r;
        case (v)
            4'd0:    r = 4'h6;
            4'd1:    r = 4'hE;
            4'd2:    r = 4'h2;
            4'd3:    r = 4'hA;
            4'd4:    r = 4'h1;
            4'd5:    r = 4'h9;
            4'd6:    r = 4'h5;
            4'd7:    r = 4'hD;
            4'd8:    r = 4'h7;
            4'd9:    r = 4'hF;
            4'd10:   r = 4'h3;
            4'd11:   r = 4'hB;
            4'd12:   r = 4'h0;
            4'd13:   r = 4'h8;
            4'd14:   r = 4'h4;
            default: r = 4'hC;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] rf_house_code(input logic [3:0] v);
        logic [3:0] r;
        case (v)
            4'd0:    r = 4'h6;
            4'd1:    r = 4'h7;
            4'd2:    r = 4'h4;
            4'd3:    r = 4'h5;
            4'd4:    r = 4'h8;
            4'd5:    r = 4'h9;
            4'd6:    r = 4'hA;
            4'd7:    r = 4'hB;
            4'd8:    r = 4'hE;
            4'd9:    r = 4'hF;
            4'd10:   r = 4'hC;
            4'd11:   r = 4'hD;
            4'd12:   r = 4'h0;
            4'd13:   r = 4'h1;
            4'd14:   r = 4'h2;
            default: r = 4'h3;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/x10_command_frame_encoder_core.sv
`timescale 1ns / 1ps
// x10 command frame encoder
// input channel (s_valid/s_ready): one x10 command per item, fields s_operation ..
// s_short_address. output channel (m_valid/m_ready): one transmit frame byte per
// item, m_last_byte marks the final byte of a frame, m_error flags a rejected
// command which yields a single item with byte 0 and m_last_byte set.
// cfg_wr_en/cfg_wr_data write omit_sync_byte; write it only while idle.
// an accepted command is queued; its first byte then moves into the output register.
// throughput: the byte serializer emits one byte per cycle while m_ready is high, so a
// command holds it for each byte of its frame (1 to 8), back to back across commands.
// a 2-entry descriptor queue sits between the classifier and the serializer;
// s_ready drops only when that queue is full.
// when m_ready is low the output register holds its item and the serializer waits;
// commands keep being accepted until the queue fills.
// reset (aresetn, synchronous, active low) empties the queue and the output stage
// and clears omit_sync_byte.
module x10_command_frame_encoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [3:0]  s_house,
    input  logic [3:0]  s_unit,
    input  logic        s_unit_present,
    input  logic [7:0]  s_function_code,
    input  logic [7:0]  s_dim_amount,
    input  logic [23:0] s_rf_address,
    input  logic        s_short_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_frame_byte,
    output logic        m_last_byte,
    output logic        m_error
);
    import x10ce_pkg::*;

    logic        omit_sync_reg;
    logic        q_full;
    logic        push;
    logic        pop;
    logic        q_valid;
    frame_desc_t push_desc;
    frame_desc_t head_desc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            omit_sync_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            omit_sync_reg <= cfg_wr_data;
        end
    end

    x10ce_front u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_house         (s_house),
        .s_unit          (s_unit),
        .s_unit_present  (s_unit_present),
        .s_function_code (s_function_code),
        .s_dim_amount    (s_dim_amount),
        .s_rf_address    (s_rf_address),
        .s_short_address (s_short_address),
        .omit_sync       (omit_sync_reg),
        .q_full          (q_full),
        .push            (push),
        .push_desc       (push_desc)
    );

    x10ce_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .head_desc (head_desc)
    );

    x10ce_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .head_desc    (head_desc),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_last_byte  (m_last_byte),
        .m_error      (m_error)
    );

endmodule

>>> hdl/x10ce_front.sv
`timescale 1ns / 1ps
module x10ce_front (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_operation,
    input  logic [3:0]            s_house,
    input  logic [3:0]            s_unit,
    input  logic                  s_unit_present,
    input  logic [7:0]            s_function_code,
    input  logic [7:0]            s_dim_amount,
    input  logic [23:0]           s_rf_address,
    input  logic                  s_short_address,
    input  logic                  omit_sync,
    input  logic                  q_full,
    output logic                  push,
    output x10ce_pkg::frame_desc_t push_desc
);
    import x10ce_pkg::*;

    typedef enum logic [2:0] {
        CLS_PL_ADDR,
        CLS_PL_FUNC,
        CLS_PL_DIM,
        CLS_PL_EXT,
        CLS_RF_STD,
        CLS_RF_SEC_SHORT,
        CLS_RF_SEC_LONG,
        CLS_ERROR
    } cmd_class_t;

    cmd_class_t cls;
    logic [3:0] pl_house;
    logic [7:0] rf_house_byte;
    logic [7:0] rf_fn_byte;
    logic [7:0] a2;
    logic       unit_bit3;

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    always_comb begin
        unique case (s_operation)
            OP_PL_ADDR: cls = CLS_PL_ADDR;
            OP_PL_FUNC: begin
                if (s_function_code == FN_DIM || s_function_code == FN_BRIGHT) begin
                    cls = CLS_PL_DIM;
                end else if (s_function_code == FN_EXT_DIM) begin
                    cls = CLS_PL_EXT;
                end else begin
                    cls = CLS_PL_FUNC;
                end
            end
            OP_RF_STD: begin
                if (s_function_code == FN_DIM || s_function_code == FN_BRIGHT) begin
                    cls = CLS_RF_STD;
                end else if ((s_function_code == FN_ON || s_function_code == FN_OFF)
                             && s_unit_present) begin
                    cls = CLS_RF_STD;
                end else begin
                    cls = CLS_ERROR;
                end
            end
            default: cls = s_short_address ? CLS_RF_SEC_SHORT : CLS_RF_SEC_LONG;
        endcase
    end

    assign pl_house      = pl_code(s_house);
    assign unit_bit3     = s_unit_present & s_unit[3];
    assign rf_house_byte = {rf_house_code(s_house), 1'b0, unit_bit3, 2'b00};
    assign a2            = s_short_address ? s_rf_address[7:0] : s_rf_address[23:16];

    always_comb begin
        if (s_function_code == FN_DIM) begin
            rf_fn_byte = RF_FN_DIM;
        end else if (s_function_code == FN_BRIGHT) begin
            rf_fn_byte = RF_FN_BRIGHT;
        end else begin
            rf_fn_byte = {1'b0, s_unit[2], (s_function_code == FN_OFF), s_unit[0],
                          s_unit[1], 3'b000};
        end
    end

    always_comb begin
        push_desc           = '0;
        push_desc.first_idx = '0;
        unique case (cls)
            CLS_PL_ADDR: begin
                push_desc.bytes[0] = HDR_PL_ADDR;
                push_desc.bytes[1] = {pl_house, pl_code(s_unit)};
                push_desc.last_idx = IDXW'(1);
            end
            CLS_PL_FUNC: begin
                push_desc.bytes[0] = HDR_PL_FUNC;
                push_desc.bytes[1] = {pl_house, s_function_code[3:0]};
                push_desc.last_idx = IDXW'(1);
            end
            CLS_PL_DIM: begin
                push_desc.bytes[0] = HDR_PL_FUNC | {s_dim_amount[4:0], 3'b000};
                push_desc.bytes[1] = {pl_house, s_function_code[3:0]};
                push_desc.last_idx = IDXW'(1);
            end
            CLS_PL_EXT: begin
                push_desc.bytes[0] = HDR_PL_EXT;
                push_desc.bytes[1] = {pl_house, 4'h7};
                push_desc.bytes[2] = EXT_CMD;
                push_desc.bytes[3] = s_dim_amount;
                push_desc.bytes[4] = EXT_TRAILER;
                push_desc.last_idx = IDXW'(4);
            end
            CLS_RF_STD: begin
                push_desc.bytes[0]  = SYNC_BYTE;
                push_desc.bytes[1]  = RF_HDR_STD;
                push_desc.bytes[2]  = rf_house_byte;
                push_desc.bytes[3]  = ~rf_house_byte;
                push_desc.bytes[4]  = rf_fn_byte;
                push_desc.bytes[5]  = ~rf_fn_byte;
                push_desc.first_idx = IDXW'(omit_sync);
                push_desc.last_idx  = IDXW'(5);
            end
            CLS_RF_SEC_SHORT: begin
                push_desc.bytes[0]  = SYNC_BYTE;
                push_desc.bytes[1]  = RF_HDR_STD;
                push_desc.bytes[2]  = a2;
                push_desc.bytes[3]  = a2 ^ ADDR_CHECK;
                push_desc.bytes[4]  = s_function_code;
                push_desc.bytes[5]  = ~s_function_code;
                push_desc.first_idx = IDXW'(omit_sync);
                push_desc.last_idx  = IDXW'(5);
            end
            CLS_RF_SEC_LONG: begin
                push_desc.bytes[0]  = SYNC_BYTE;
                push_desc.bytes[1]  = RF_HDR_LONG;
                push_desc.bytes[2]  = a2;
                push_desc.bytes[3]  = a2 ^ ADDR_CHECK;
                push_desc.bytes[4]  = s_function_code;
                push_desc.bytes[5]  = ~s_function_code;
                push_desc.bytes[6]  = s_rf_address[15:8];
                push_desc.bytes[7]  = s_rf_address[7:0];
                push_desc.first_idx = IDXW'(omit_sync);
                push_desc.last_idx  = IDXW'(7);
            end
            default: begin
                push_desc.error    = 1'b1;
                push_desc.last_idx = '0;
            end
        endcase
    end

endmodule

>>> hdl/x10ce_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module x10ce_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  x10ce_pkg::frame_desc_t push_desc,
    output logic                   full,
    input  logic                   pop,
    output logic                   q_valid,
    output x10ce_pkg::frame_desc_t head_desc
);
    import x10ce_pkg::*;

    frame_desc_t       mem [QDEPTH];
    logic [QPTRW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTRW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNTW-1:0]  count_reg, count_next;

    function automatic logic [QPTRW-1:0] ptr_inc(input logic [QPTRW-1:0] p);
        return (p == QPTRW'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full      = (count_reg == QCNTW'(QDEPTH));
    assign q_valid   = (count_reg != '0);
    assign head_desc = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

    `ASSERT_CLK(a_count_bound, (count_reg <= QCNTW'(QDEPTH)), "queue count beyond depth")
    `ASSERT_CLK(a_no_underflow, (pop |-> q_valid), "pop from empty queue")

endmodule

>>> hdl/x10ce_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module x10ce_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    input  x10ce_pkg::frame_desc_t head_desc,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_frame_byte,
    output logic                   m_last_byte,
    output logic                   m_error
);
    import x10ce_pkg::*;

    logic                      act_reg, act_next;
    logic [FRAME_MAX-1:0][7:0] bytes_reg, bytes_next;
    logic [IDXW-1:0]           idx_reg, idx_next;
    logic [IDXW-1:0]           end_reg, end_next;
    logic                      valid_reg, valid_next;
    logic [7:0]                byte_reg, byte_next;
    logic                      last_reg, last_next;
    logic                      err_reg, err_next;
    logic                      out_load;
    logic                      head_last;

    assign out_load  = !valid_reg || m_ready;
    assign head_last = (head_desc.first_idx == head_desc.last_idx);
    assign pop       = out_load && !act_reg && q_valid;

    always_comb begin
        act_next   = act_reg;
        bytes_next = bytes_reg;
        idx_next   = idx_reg;
        end_next   = end_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        err_next   = err_reg;
        if (out_load) begin
            if (act_reg) begin
                valid_next = 1'b1;
                byte_next  = bytes_reg[idx_reg];
                last_next  = (idx_reg == end_reg);
                err_next   = 1'b0;
                act_next   = (idx_reg != end_reg);
                idx_next   = idx_reg + 1'b1;
            end else if (q_valid) begin
                valid_next = 1'b1;
                byte_next  = head_desc.bytes[head_desc.first_idx];
                last_next  = head_last;
                err_next   = head_desc.error;
                act_next   = !head_last;
                bytes_next = head_desc.bytes;
                idx_next   = head_desc.first_idx + 1'b1;
                end_next   = head_desc.last_idx;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            act_reg   <= act_next;
            valid_reg <= valid_next;
        end
        bytes_reg <= bytes_next;
        idx_reg   <= idx_next;
        end_reg   <= end_next;
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        err_reg   <= err_next;
    end

    assign m_valid      = valid_reg;
    assign m_frame_byte = byte_reg;
    assign m_last_byte  = last_reg;
    assign m_error      = err_reg;

    `ASSERT_CLK(a_err_alone, (valid_reg && err_reg |-> last_reg && byte_reg == 8'h00), "error item must be a lone zero last item")
    `ASSERT_CLK(a_active_has_more, (act_reg |-> valid_reg && !last_reg), "frame still active after its last item")

endmodule
